@@ rtl/core/smsort_pkg.sv @@
// Shared word types and widths for the stable merge sorter.
`timescale 1ns / 1ps

package smsort_pkg;

	localparam int DATA_W = 32;

	// Input word: one element of the sequence, last marks the end of the run
	typedef struct packed {
		logic signed [DATA_W-1:0] value;
		logic                     last;
	} in_word_t;

	// Output word: one element of the sorted run
	typedef struct packed {
		logic signed [DATA_W-1:0] value_res;
		logic                     last_res;
		logic                     overflow;
	} out_word_t;

endpackage

@@ rtl/core/smsort_ram.sv @@
// Element RAM: one write port, two read ports with registered read data.
`timescale 1ns / 1ps

module smsort_ram #(
	parameter int DEPTH  = 64,
	parameter int ADDR_W = 6
) (
	input  logic                          clk,
	input  logic                          wr_en,
	input  logic [ADDR_W-1:0]             wr_addr,
	input  logic [smsort_pkg::DATA_W-1:0] wr_data,
	input  logic                          rd_en,
	input  logic [ADDR_W-1:0]             rd_addr_a,
	input  logic [ADDR_W-1:0]             rd_addr_b,
	output logic [smsort_pkg::DATA_W-1:0] rd_data_a,
	output logic [smsort_pkg::DATA_W-1:0] rd_data_b
);
	import smsort_pkg::*;

	logic [DATA_W-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Read ports; data holds while rd_en is low
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_a <= mem[rd_addr_a];
			rd_data_b <= mem[rd_addr_b];
		end
	end

endmodule

@@ rtl/core/stable_merge_sorter.sv @@
// Stable ascending merge sorter: load, bottom-up merge passes, sorted read-out.
//
//  channel  | handshake                    | word
//  ---------+------------------------------+-------------------------------
//  sample   | sample_valid / sample_ready  | value, last
//  result   | result_valid / result_ready  | value_res, last_res, overflow
//
// A run of n words is loaded, then sorted by ceil(log2 n) merge passes. Each run pair is
// primed in S_PRIME and merged in S_MERGE one word at a time through the single write
// port of the target RAM, with S_SETUP before each pass; a last S_SETUP leads to read-out
// via the registered RAM read and the output register. Reset clears control state only,
// not the RAMs. sample_ready is high only while loading; result stalls hold the read-out,
// and merging waits in setup until the previous run's read-out stage has emptied.
`timescale 1ns / 1ps

module stable_merge_sorter #(
	parameter int MAX_ITEMS = 64
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  sample_valid,
	output logic                  sample_ready,
	input  smsort_pkg::in_word_t  sample,
	output logic                  result_valid,
	input  logic                  result_ready,
	output smsort_pkg::out_word_t result
);
	import smsort_pkg::*;

	localparam int CNT_W  = $clog2(MAX_ITEMS + 1);
	localparam int ADDR_W = $clog2(MAX_ITEMS);
	localparam int SUM_W  = CNT_W + 2;

	typedef enum logic [4:0] {
		S_LOAD  = 5'b00001,
		S_SETUP = 5'b00010,
		S_PRIME = 5'b00100,
		S_MERGE = 5'b01000,
		S_EMIT  = 5'b10000
	} state_t;

	state_t            state_q;
	logic [CNT_W-1:0]  count_q;
	logic              dropped_q;
	logic [SUM_W-1:0]  width_q;
	logic              src_a_q;
	logic [CNT_W-1:0]  lo_q, mid_q, hi_q, i_q, j_q, k_q;
	logic [CNT_W-1:0]  emit_ptr_q;

	logic              s1_v_q;
	logic              s1_last_s1, s1_ovf_s1, s1_sel_s1;
	logic              out_v_q;
	out_word_t         out_q;

	// RAM ports
	logic                a_wr_en, b_wr_en, rd_en;
	logic [ADDR_W-1:0]   a_wr_addr, b_wr_addr;
	logic [DATA_W-1:0]   a_wr_data, merge_data;
	logic [CNT_W-1:0]    rd_i, rd_j;
	logic [DATA_W-1:0]   a_rd_a, a_rd_b, b_rd_a, b_rd_b;

	// Merge datapath
	logic signed [DATA_W-1:0] da, db;
	logic              i_live, j_live, take_left;
	logic [CNT_W-1:0]  i_nxt, j_nxt, k_nxt;
	logic              run_done, pass_done;
	logic [SUM_W-1:0]  n_ext, mid_sum, hi_sum;
	logic [CNT_W-1:0]  mid_c, hi_c;

	logic              load_acc, store_ok;
	logic              s1_adv, emit_issue, emit_final;

	assign sample_ready = (state_q == S_LOAD);
	assign load_acc     = sample_valid && sample_ready;
	assign store_ok     = (count_q < CNT_W'(MAX_ITEMS));

	// Run bounds for the next pair of runs
	assign n_ext   = SUM_W'(count_q);
	assign mid_sum = SUM_W'(lo_q) + width_q;
	assign hi_sum  = SUM_W'(lo_q) + (width_q << 1);
	assign mid_c   = (mid_sum > n_ext) ? count_q : mid_sum[CNT_W-1:0];
	assign hi_c    = (hi_sum > n_ext) ? count_q : hi_sum[CNT_W-1:0];

	// Merge step: take from the left run on ties
	assign da        = src_a_q ? $signed(a_rd_a) : $signed(b_rd_a);
	assign db        = src_a_q ? $signed(a_rd_b) : $signed(b_rd_b);
	assign i_live    = (i_q < mid_q);
	assign j_live    = (j_q < hi_q);
	assign take_left = i_live && (!j_live || (da <= db));
	assign merge_data = take_left ? da : db;
	assign i_nxt     = i_q + CNT_W'(take_left);
	assign j_nxt     = j_q + CNT_W'(!take_left);
	assign k_nxt     = k_q + CNT_W'(1);
	assign run_done  = (k_nxt == hi_q);
	assign pass_done = run_done && (hi_q == count_q);

	// Read-out pipeline
	assign s1_adv     = s1_v_q && (!out_v_q || result_ready);
	assign emit_issue = (state_q == S_EMIT) && (!s1_v_q || s1_adv);
	assign emit_final = (emit_ptr_q + CNT_W'(1) == count_q);

	// Read address selection
	always_comb begin
		rd_i  = '0;
		rd_j  = '0;
		rd_en = 1'b0;
		unique case (state_q)
			S_PRIME: begin
				rd_i  = lo_q;
				rd_j  = mid_c;
				rd_en = 1'b1;
			end
			S_MERGE: begin
				rd_i  = i_nxt;
				rd_j  = j_nxt;
				rd_en = 1'b1;
			end
			S_EMIT: begin
				rd_i  = emit_ptr_q;
				rd_en = emit_issue;
			end
			default: begin
				rd_en = 1'b0;
			end
		endcase
	end

	// Write port selection: loads go to A, merges go to the other buffer
	always_comb begin
		a_wr_en   = 1'b0;
		a_wr_addr = k_q[ADDR_W-1:0];
		a_wr_data = merge_data;
		b_wr_en   = (state_q == S_MERGE) && src_a_q;
		b_wr_addr = k_q[ADDR_W-1:0];
		if (state_q == S_LOAD) begin
			a_wr_en   = load_acc && store_ok;
			a_wr_addr = count_q[ADDR_W-1:0];
			a_wr_data = sample.value;
		end else if (state_q == S_MERGE) begin
			a_wr_en = !src_a_q;
		end
	end

	smsort_ram #(.DEPTH(MAX_ITEMS), .ADDR_W(ADDR_W)) u_ram_a (
		.clk       (clk),
		.wr_en     (a_wr_en),
		.wr_addr   (a_wr_addr),
		.wr_data   (a_wr_data),
		.rd_en     (rd_en),
		.rd_addr_a (rd_i[ADDR_W-1:0]),
		.rd_addr_b (rd_j[ADDR_W-1:0]),
		.rd_data_a (a_rd_a),
		.rd_data_b (a_rd_b)
	);

	smsort_ram #(.DEPTH(MAX_ITEMS), .ADDR_W(ADDR_W)) u_ram_b (
		.clk       (clk),
		.wr_en     (b_wr_en),
		.wr_addr   (b_wr_addr),
		.wr_data   (merge_data),
		.rd_en     (rd_en),
		.rd_addr_a (rd_i[ADDR_W-1:0]),
		.rd_addr_b (rd_j[ADDR_W-1:0]),
		.rd_data_a (b_rd_a),
		.rd_data_b (b_rd_b)
	);

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_LOAD;
			count_q    <= '0;
			dropped_q  <= 1'b0;
			width_q    <= '0;
			src_a_q    <= 1'b1;
			lo_q       <= '0;
			mid_q      <= '0;
			hi_q       <= '0;
			i_q        <= '0;
			j_q        <= '0;
			k_q        <= '0;
			emit_ptr_q <= '0;
		end else begin
			unique case (state_q)
				S_LOAD: begin
					if (load_acc) begin
						if (store_ok) begin
							count_q <= count_q + CNT_W'(1);
						end else begin
							dropped_q <= 1'b1;
						end
						if (sample.last) begin
							width_q <= SUM_W'(1);
							src_a_q <= 1'b1;
							state_q <= S_SETUP;
						end
					end
				end
				S_SETUP: begin
					if (width_q >= n_ext) begin
						emit_ptr_q <= '0;
						state_q    <= S_EMIT;
					end else if (!s1_v_q) begin
						// previous read-out must drain before the RAM reads are reused
						lo_q    <= '0;
						state_q <= S_PRIME;
					end
				end
				S_PRIME: begin
					mid_q   <= mid_c;
					hi_q    <= hi_c;
					i_q     <= lo_q;
					j_q     <= mid_c;
					k_q     <= lo_q;
					state_q <= S_MERGE;
				end
				S_MERGE: begin
					i_q <= i_nxt;
					j_q <= j_nxt;
					k_q <= k_nxt;
					if (pass_done) begin
						width_q <= width_q << 1;
						src_a_q <= !src_a_q;
						state_q <= S_SETUP;
					end else if (run_done) begin
						lo_q    <= hi_q;
						state_q <= S_PRIME;
					end
				end
				S_EMIT: begin
					if (emit_issue) begin
						emit_ptr_q <= emit_ptr_q + CNT_W'(1);
						if (emit_final) begin
							count_q   <= '0;
							dropped_q <= 1'b0;
							state_q   <= S_LOAD;
						end
					end
				end
				default: begin
					state_q <= S_LOAD;
				end
			endcase
		end
	end

	// Read-out valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v_q  <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (emit_issue) begin
				s1_v_q <= 1'b1;
			end else if (s1_adv) begin
				s1_v_q <= 1'b0;
			end
			if (s1_adv) begin
				out_v_q <= 1'b1;
			end else if (result_ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	// Read-out payload
	always_ff @(posedge clk) begin
		if (emit_issue) begin
			s1_last_s1 <= emit_final;
			s1_ovf_s1  <= dropped_q;
			s1_sel_s1  <= src_a_q;
		end
		if (s1_adv) begin
			out_q.value_res <= s1_sel_s1 ? $signed(a_rd_a) : $signed(b_rd_a);
			out_q.last_res  <= s1_last_s1;
			out_q.overflow  <= s1_ovf_s1;
		end
	end

	assign result_valid = out_v_q;
	assign result       = out_q;

`ifndef NO_ASSERTIONS
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_ITEMS))
		else $error("element count beyond capacity");

	a_merge_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MERGE) |-> (k_q < hi_q && i_q <= mid_q && j_q <= hi_q))
		else $error("merge indexes out of run bounds");

	a_prime_drained: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_PRIME) |-> !s1_v_q)
		else $error("merge reads started while read-out stage busy");

	a_emit_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EMIT) |-> (emit_ptr_q < count_q))
		else $error("read-out pointer past stored elements");
`endif

endmodule

@@ verif/testbench.sv @@
// Self-checking testbench for the stable merge sorter: directed runs, then random runs.
`timescale 1ns / 1ps

module testbench;
	import smsort_pkg::*;

	localparam int CAPACITY    = 64;
	localparam int RANDOM_GOAL = 105;  // includes the long overflow run
	localparam int CALM_FROM   = 85;   // no idling past this many random words
	localparam int DRAIN_WAIT  = 50;

	typedef logic signed [DATA_W-1:0] elem_t;
	typedef out_word_t word_q_t[$];

	// Directed row; sorted_value is typed in only for single-element runs
	typedef struct {
		elem_t value;
		bit    last;
		bit    typed;
		elem_t sorted_value;
	} stim_row_t;

	localparam elem_t MIN_VAL = 32'sh8000_0000;
	localparam elem_t MAX_VAL = 32'sh7fff_ffff;

	logic      clk;
	logic      arst_n;
	logic      sample_valid;
	logic      sample_ready;
	in_word_t  sample;
	logic      result_valid;
	logic      result_ready;
	out_word_t result;

	// Predictor state: elements of the open run and its drop flag
	elem_t   pending_run[$];
	bit      pending_dropped;
	word_q_t sorted_due;

	int  failures;
	bit  calm;

	stim_row_t directed_rows [23] = '{
		'{MIN_VAL,       1'b1, 1'b1, MIN_VAL},
		'{MAX_VAL,       1'b1, 1'b1, MAX_VAL},
		'{32'sd0,        1'b1, 1'b1, 32'sd0},
		'{-32'sd1,       1'b1, 1'b1, -32'sd1},
		'{32'sd5,        1'b0, 1'b0, 32'sd0},
		'{-32'sd3,       1'b0, 1'b0, 32'sd0},
		'{32'sd5,        1'b0, 1'b0, 32'sd0},
		'{MAX_VAL,       1'b0, 1'b0, 32'sd0},
		'{MIN_VAL,       1'b1, 1'b0, 32'sd0},
		'{32'sd7,        1'b0, 1'b0, 32'sd0},
		'{32'sd7,        1'b1, 1'b0, 32'sd0},
		'{32'sd3,        1'b0, 1'b0, 32'sd0},
		'{32'sd2,        1'b0, 1'b0, 32'sd0},
		'{32'sd1,        1'b0, 1'b0, 32'sd0},
		'{32'sd0,        1'b0, 1'b0, 32'sd0},
		'{-32'sd1,       1'b0, 1'b0, 32'sd0},
		'{-32'sd2,       1'b0, 1'b0, 32'sd0},
		'{-32'sd3,       1'b1, 1'b0, 32'sd0},
		'{32'sd1,        1'b0, 1'b0, 32'sd0},
		'{32'shffff_fffe, 1'b0, 1'b0, 32'sd0},
		'{32'sh4000_0000, 1'b1, 1'b0, 32'sd0},
		'{32'sh5555_5555, 1'b0, 1'b0, 32'sd0},
		'{32'shaaaa_aaaa, 1'b1, 1'b0, 32'sd0}
	};

	stable_merge_sorter #(.MAX_ITEMS(CAPACITY)) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_ready (sample_ready),
		.sample       (sample),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	always #1 clk = ~clk;

	// Stores one word; on a last word returns the run sorted, ties in arrival order
	task automatic sort_run(input in_word_t w, output word_q_t run_out);
		elem_t ordered[$];
		elem_t key;
		int    j;
		run_out = {};
		if (pending_run.size() < CAPACITY)
			pending_run.push_back(w.value);
		else
			pending_dropped = 1'b1;
		if (w.last) begin
			ordered = pending_run;
			for (int i = 1; i < ordered.size(); i++) begin
				key = ordered[i];
				j = i - 1;
				while (j >= 0 && ordered[j] > key) begin
					ordered[j + 1] = ordered[j];
					j--;
				end
				ordered[j + 1] = key;
			end
			foreach (ordered[k])
				run_out.push_back(out_word_t'{value_res: ordered[k],
					last_res: (k == ordered.size() - 1), overflow: pending_dropped});
			pending_run = {};
			pending_dropped = 1'b0;
		end
	endtask

	// Drives one word until accepted, then records what it should produce
	task automatic send_word(input in_word_t w, input bit typed, input elem_t typed_value);
		word_q_t run_out;
		@(negedge clk);
		sample       <= w;
		sample_valid <= 1'b1;
		do @(posedge clk); while (!sample_ready);
		sort_run(w, run_out);
		if (typed)
			sorted_due.push_back(out_word_t'{value_res: typed_value, last_res: 1'b1,
				overflow: 1'b0});
		else
			foreach (run_out[k])
				sorted_due.push_back(run_out[k]);
	endtask

	task automatic idle_sender(input int cycles);
		@(negedge clk);
		sample_valid <= 1'b0;
		repeat (cycles - 1) @(negedge clk);
	endtask

	function automatic elem_t pick_value();
		case ($urandom_range(0, 7))
			0: return MIN_VAL;
			1: return MAX_VAL;
			2, 3: return elem_t'($urandom_range(0, 8)) - 32'sd4;  // dense, many ties
			default: return elem_t'($urandom());
		endcase
	endfunction

	// Stimulus
	initial begin
		in_word_t w;
		int       sent;
		int       runs;
		int       run_len;
		clk          = 1'b0;
		arst_n       = 1'b0;
		sample_valid = 1'b0;
		sample       = '0;
		calm         = 1'b0;
		failures     = 0;
		pending_dropped = 1'b0;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;

		foreach (directed_rows[r]) begin
			w.value = directed_rows[r].value;
			w.last  = directed_rows[r].last;
			send_word(w, directed_rows[r].typed, directed_rows[r].sorted_value);
			if ($urandom_range(0, 3) == 0)
				idle_sender($urandom_range(1, 5));
		end

		// Hold off until the directed runs have fully drained
		idle_sender(1);
		while (sorted_due.size() != 0)
			@(posedge clk);

		// Random runs; one long run fills the store exactly, then drops the rest and the last
		sent = 0;
		runs = 0;
		while (sent < RANDOM_GOAL || runs <= 2) begin
			case (runs)
				2: run_len = CAPACITY + 2;
				default: run_len = ($urandom_range(0, 5) == 0) ? $urandom_range(13, 40)
					: $urandom_range(1, 12);
			endcase
			for (int i = 0; i < run_len; i++) begin
				calm = (sent >= CALM_FROM);
				w.value = pick_value();
				w.last  = (i == run_len - 1);
				send_word(w, 1'b0, '0);
				sent++;
				if (!calm && $urandom_range(0, 3) == 0)
					idle_sender($urandom_range(1, 5));
			end
			runs++;
		end
		idle_sender(1);

		while (sorted_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (failures == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	// Result side: random stall bursts until the calm tail
	initial begin
		result_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (calm || $urandom_range(0, 4) != 0) begin
				result_ready <= 1'b1;
			end else begin
				result_ready <= 1'b0;
				repeat ($urandom_range(1, 5) - 1) @(negedge clk);
			end
		end
	end

	// Compare each accepted result word with the oldest expected one
	always @(posedge clk) begin : check_results
		out_word_t want;
		if (arst_n && result_valid && result_ready) begin
			if (sorted_due.size() == 0) begin
				failures++;
				if (failures <= 10)
					$display("unexpected result word: value %0d last %0b ovf %0b",
						result.value_res, result.last_res, result.overflow);
			end else begin
				want = sorted_due.pop_front();
				if (result.value_res !== want.value_res || result.last_res !== want.last_res
						|| result.overflow !== want.overflow) begin
					failures++;
					if (failures <= 10)
						$display("mismatch: got value %0d last %0b ovf %0b, want value %0d last %0b ovf %0b",
							result.value_res, result.last_res, result.overflow,
							want.value_res, want.last_res, want.overflow);
				end
			end
		end
	end

	// Watchdog
	initial begin
		#2_000_000;
		$display("Simulation FAILED");
		$finish;
	end

endmodule
